/* hdl/sotr_pkg.sv */
`timescale 1ns / 1ps

package sotr_pkg;

  localparam int CUR_W   = 16;
  localparam int CNT_W   = 16;
  localparam int CLAMP_W = 15;
  localparam int DIV_W   = 16;
  localparam int CFG_INDEX_W = 8;
  localparam int CFG_DATA_W  = 16;

  // Serial passes: one bit of every operand per cycle
  localparam int SCAN_BITS = 16;
  localparam int DIV_BITS  = CLAMP_W;
  localparam int BIT_CNT_W = 4;

  localparam logic [BIT_CNT_W-1:0] SCAN_LAST = BIT_CNT_W'(SCAN_BITS - 1);
  localparam logic [BIT_CNT_W-1:0] DIV_LAST  = BIT_CNT_W'(DIV_BITS - 1);

  localparam logic [CUR_W-1:0]   CURRENT_THRESHOLD_RST = 16'd1500;
  localparam logic [CNT_W-1:0]   TRIP_TIMEOUT_RST      = 16'd50;
  localparam logic [CLAMP_W-1:0] CLAMP_MAX_RST         = 15'd31128;
  localparam logic [DIV_W-1:0]   COAST_TICKS_RST       = 16'd100;

  localparam logic [CFG_INDEX_W-1:0] REG_CURRENT_THRESHOLD = 8'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_TRIP_TIMEOUT      = 8'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_CLAMP_MAX         = 8'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_COAST_TICKS       = 8'd3;

endpackage

/* hdl/sustained_overcurrent_trip_ramp_core.sv */
`timescale 1ns / 1ps

// Channel | Handshake            | Payload
// --------+----------------------+-------------------------------------------
// in      | in_valid / in_ready  | measured_current[15:0], control_value[14:0]
// out     | out_valid / out_ready| clamp_value[14:0], tripped, stop_request
// cfg     | cfg_valid / cfg_ready| cfg_index[7:0], cfg_data[15:0]
//
// A normal tick runs from input transfer to a result in the output register
// through a bit-serial compare/increment/subtract pass, a decide step and an
// output register load. The trip tick adds a pass through the
// restoring divider, one quotient bit per cycle.
// Reset (rst, synchronous) restores the register defaults, clears the trip and
// the counter and sets the clamp to the clamp_max default.
// A stalled output holds its result; the next input is taken meanwhile, and its
// result waits in the done state until the output register frees up.
// cfg_ready is always high; write registers only while the block is idle.

module sustained_overcurrent_trip_ramp_core
  import sotr_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst,
  // input channel
  input  logic                   in_valid,
  output logic                   in_ready,
  input  logic [CUR_W-1:0]       measured_current,
  input  logic [CLAMP_W-1:0]     control_value,
  // result channel
  output logic                   out_valid,
  input  logic                   out_ready,
  output logic [CLAMP_W-1:0]     clamp_value,
  output logic                   tripped,
  output logic                   stop_request,
  // configuration write channel
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_EVAL,
    S_DIV,
    S_DONE
  } state_t;

  state_t state;

  // configuration registers
  logic [CUR_W-1:0]   current_threshold;
  logic [CNT_W-1:0]   trip_timeout;
  logic [CLAMP_W-1:0] clamp_max;
  logic [DIV_W-1:0]   coast_ticks;

  // architectural state
  logic [CNT_W-1:0]   over_count;
  logic               trip_latched;
  logic [CLAMP_W-1:0] clamp_level;
  logic [CLAMP_W-1:0] ramp_step;

  // serial datapath: operands shift out LSB first, one bit per cycle
  logic [SCAN_BITS-1:0] a_sh;   // current, or clamp with difference shifted in
  logic [SCAN_BITS-1:0] b_sh;   // threshold, or ramp step
  logic [CNT_W-1:0]     c_sh;   // over_count, rotated through the incrementer
  logic [CNT_W-1:0]     d_sh;   // trip timeout
  logic                 gt_ab;  // a > b over the bits seen so far
  logic                 lt_cd;  // c < d over the bits seen so far
  logic                 carry;
  logic                 borrow;
  logic                 nz_a;
  logic [BIT_CNT_W-1:0] bit_cnt;
  logic [CLAMP_W-1:0]   ctl_r;

  // divider
  logic [DIV_W-1:0]   div_r;
  logic [DIV_W-1:0]   rem;
  logic [CLAMP_W-1:0] q_sh;     // dividend bits out of the top, quotient in

  // result waiting for the output register
  logic [CLAMP_W-1:0] res_clamp;
  logic               res_trip;
  logic               res_stop;

  logic               a0, b0, c0, d0;
  logic               diff_bit;
  logic               borrow_next;
  logic [DIV_W:0]     trial;
  logic               q_bit;
  logic [DIV_W-1:0]   rem_next;
  logic               out_free;

  always_comb begin
    a0 = a_sh[0];
    b0 = b_sh[0];
    c0 = c_sh[0];
    d0 = d_sh[0];
    diff_bit    = a0 ^ b0 ^ borrow;
    borrow_next = (~a0 & b0) | (~(a0 ^ b0) & borrow);

    // restoring division step: bring down the next dividend bit, try subtract
    trial    = {rem, q_sh[CLAMP_W-1]};
    q_bit    = (trial >= {1'b0, div_r});
    rem_next = q_bit ? DIV_W'(trial - {1'b0, div_r}) : trial[DIV_W-1:0];

    out_free = !out_valid || out_ready;
  end

  assign in_ready  = (state == S_IDLE);
  assign cfg_ready = 1'b1;

  // Configuration writes; indexes past the register list drop silently
  always_ff @(posedge clk) begin
    if (rst) begin
      current_threshold <= CURRENT_THRESHOLD_RST;
      trip_timeout      <= TRIP_TIMEOUT_RST;
      clamp_max         <= CLAMP_MAX_RST;
      coast_ticks       <= COAST_TICKS_RST;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_CURRENT_THRESHOLD: current_threshold <= cfg_data;
        REG_TRIP_TIMEOUT:      trip_timeout      <= cfg_data;
        REG_CLAMP_MAX:         clamp_max         <= cfg_data[CLAMP_W-1:0];
        REG_COAST_TICKS:       coast_ticks       <= cfg_data;
        default: ;
      endcase
    end
  end

  // Sequencer, serial datapath and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      out_valid    <= 1'b0;
      over_count   <= '0;
      trip_latched <= 1'b0;
      clamp_level  <= CLAMP_MAX_RST;
      ramp_step    <= '0;
      bit_cnt      <= '0;
    end else begin
      // drop the result once the consumer takes it; the done state reloads it
      if (out_valid && out_ready && state != S_DONE) begin
        out_valid <= 1'b0;
      end

      unique case (state)
        S_IDLE: begin
          if (in_valid) begin
            // after a trip the same serial pass does clamp minus step
            if (trip_latched) begin
              a_sh <= {1'b0, clamp_level};
              b_sh <= {1'b0, ramp_step};
            end else begin
              a_sh <= measured_current;
              b_sh <= current_threshold;
            end
            c_sh    <= over_count;
            d_sh    <= trip_timeout;
            ctl_r   <= control_value;
            gt_ab   <= 1'b0;
            lt_cd   <= 1'b0;
            carry   <= 1'b1;
            borrow  <= 1'b0;
            nz_a    <= 1'b0;
            bit_cnt <= '0;
            state   <= S_SCAN;
          end
        end

        S_SCAN: begin
          // advance one bit: compare, increment and subtract side by side
          gt_ab  <= (a0 & ~b0) | (~(a0 ^ b0) & gt_ab);
          lt_cd  <= (d0 & ~c0) | (~(d0 ^ c0) & lt_cd);
          borrow <= borrow_next;
          carry  <= c0 & carry;
          nz_a   <= nz_a | a0;
          a_sh   <= {diff_bit, a_sh[SCAN_BITS-1:1]};
          b_sh   <= {1'b0, b_sh[SCAN_BITS-1:1]};
          c_sh   <= {c0 ^ carry, c_sh[CNT_W-1:1]};
          d_sh   <= {1'b0, d_sh[CNT_W-1:1]};
          bit_cnt <= bit_cnt + 1'b1;
          if (bit_cnt == SCAN_LAST) begin
            state <= S_EVAL;
          end
        end

        S_EVAL: begin
          if (!trip_latched) begin
            clamp_level <= clamp_max;
            res_clamp   <= clamp_max;
            res_trip    <= 1'b0;
            res_stop    <= 1'b0;
            if (!gt_ab) begin
              over_count <= '0;
              state      <= S_DONE;
            end else if (lt_cd) begin
              // c_sh now holds over_count + 1
              over_count <= c_sh;
              state      <= S_DONE;
            end else begin
              // sustained overcurrent: latch the clamp, derive the ramp step
              div_r   <= (coast_ticks == '0) ? DIV_W'(1) : coast_ticks;
              rem     <= '0;
              q_sh    <= ctl_r;
              bit_cnt <= '0;
              state   <= S_DIV;
            end
          end else begin
            res_trip <= 1'b1;
            if (!nz_a) begin
              clamp_level <= '0;
              res_clamp   <= '0;
              res_stop    <= 1'b1;
            end else begin
              // a borrow out means the step overshoots: saturate at zero
              clamp_level <= borrow ? '0 : a_sh[CLAMP_W-1:0];
              res_clamp   <= borrow ? '0 : a_sh[CLAMP_W-1:0];
              res_stop    <= 1'b0;
            end
            state <= S_DONE;
          end
        end

        S_DIV: begin
          rem     <= rem_next;
          q_sh    <= {q_sh[CLAMP_W-2:0], q_bit};
          bit_cnt <= bit_cnt + 1'b1;
          if (bit_cnt == DIV_LAST) begin
            trip_latched <= 1'b1;
            clamp_level  <= ctl_r;
            ramp_step    <= {q_sh[CLAMP_W-2:0], q_bit};
            res_clamp    <= ctl_r;
            res_trip     <= 1'b1;
            res_stop     <= 1'b0;
            state        <= S_DONE;
          end
        end

        S_DONE: begin
          // hold until the output register is free, then transfer into it
          if (out_free) begin
            clamp_value  <= res_clamp;
            tripped      <= res_trip;
            stop_request <= res_stop;
            out_valid    <= 1'b1;
            state        <= S_IDLE;
          end else begin
            out_valid    <= 1'b1;
          end
        end

        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

/* hdl/sotr_checker.sv */
`timescale 1ns / 1ps

module sotr_checker
  import sotr_pkg::*;
(
  input logic               clk,
  input logic               rst,
  input logic               in_valid,
  input logic               in_ready,
  input logic               out_valid,
  input logic               out_ready,
  input logic [CLAMP_W-1:0] clamp_value,
  input logic               tripped,
  input logic               stop_request
);

  logic       seen_trip;
  logic [1:0] pending;

  always_ff @(posedge clk) begin
    if (rst) begin
      seen_trip <= 1'b0;
      pending   <= '0;
    end else begin
      if (out_valid && out_ready && tripped) begin
        seen_trip <= 1'b1;
      end
      pending <= pending + 2'((in_valid && in_ready) ? 1 : 0)
                         - 2'((out_valid && out_ready) ? 1 : 0);
    end
  end

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(clamp_value)
      && $stable(tripped) && $stable(stop_request))
    else $error("result changed while stalled");

  // the trip is permanent
  a_trip_sticky: assert property (@(posedge clk) disable iff (rst)
    out_valid && seen_trip |-> tripped)
    else $error("tripped fell after a trip");

  // stop only once tripped with the clamp at zero
  a_stop_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && stop_request |-> tripped && clamp_value == '0)
    else $error("stop without a tripped zero clamp");

  // no result without an accepted tick behind it
  a_no_invent: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> pending != 2'd0)
    else $error("result with no outstanding input");

endmodule

bind sustained_overcurrent_trip_ramp_core sotr_checker u_sotr_checker (.*);
